// ===== src/websocket_frame_deframer_assert.svh =====
// Assertion macros shared by the deframer checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// Clocked assertion that is switched off while reset is held low.
`define WSDF_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define WSDF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/wsdf_pkg.sv =====
// Types and constants of the frame deframer.
// Used by the top level and the checker; depends on nothing.
package wsdf_pkg;

    localparam logic       KIND_HEADER   = 1'b0;
    localparam logic       KIND_PAYLOAD  = 1'b1;
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [3:0] EXT16_BYTES   = 4'd2;
    localparam logic [3:0] EXT64_BYTES   = 4'd8;
    localparam logic [2:0] KEY_BYTES     = 3'd4;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [3:0]  frame_opcode;
        logic        final_fragment;
        logic        was_masked;
        logic [63:0] payload_length;
        logic        end_of_frame;
    } t_result;

endpackage

// ===== src/wsdf_if.sv =====
// Valid/ready channel interfaces for the deframer: received bytes in, results out.
// Depends on nothing; the result fields are declared here directly.
interface wsdf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsdf_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [3:0]  frame_opcode;
    logic        final_fragment;
    logic        was_masked;
    logic [63:0] payload_length;
    logic        end_of_frame;

    modport source (output valid, output kind, output payload_byte, output frame_opcode,
                    output final_fragment, output was_masked, output payload_length,
                    output end_of_frame, input ready);
    modport sink (input valid, input kind, input payload_byte, input frame_opcode,
                  input final_fragment, input was_masked, input payload_length,
                  input end_of_frame, output ready);
endinterface

// ===== src/websocket_frame_deframer.sv =====
// Frame deframer top level: parses the header and unmasks the payload of a byte stream.
// Depends on wsdf_pkg and the channel interfaces in wsdf_if.sv.
//
// The i_rx channel takes one received byte per transaction. Header bytes give no
// result except the byte that completes the header, which gives a header result
// (kind 0). Every payload byte gives one payload result (kind 1), unmasked with the
// rotating key when the frame is masked, with end_of_frame set on the last one.
// The parser decodes each byte in the cycle it is taken, so a byte is taken every clock
// while the skid stage is empty; its result goes to the output register, or to the skid
// stage if o_res stalls. The parse state registers set this one-byte-per-cycle figure.
// The output register is backed by a one-entry skid stage: while o_res is stalled
// the block keeps taking bytes until one more result waits in that stage;
// i_rx.ready drops only when that stage is full.
// A synchronous low i_rst_n returns the parser to waiting for the first header byte
// and empties the output; results in flight are dropped.
// LENGTH_BITS sets the width of the held frame length; longer lengths saturate.
module websocket_frame_deframer #(
    parameter int LENGTH_BITS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wsdf_in_if.sink           i_rx,
    wsdf_out_if.source        o_res
);

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic                   r_fin, n_fin;
    logic [3:0]             r_opcode, n_opcode;
    logic                   r_mask, n_mask;
    logic [3:0]             r_len_left, n_len_left;
    logic [2:0]             r_key_left, n_key_left;
    logic [LENGTH_BITS-1:0] r_rem, n_rem;
    logic [LENGTH_BITS-1:0] r_flen, n_flen;
    logic [31:0]            r_key, n_key;
    logic [1:0]             r_pos, n_pos;

    logic                   r_out_valid;
    logic                   r_skid_valid;
    wsdf_pkg::t_result      r_out, r_skid, n_res;
    logic                   n_has_res;
    logic                   finish;
    logic                   accept;
    logic [7:0]             key_byte;
    logic [7:0]             b;

    assign b          = i_rx.rx_byte;
    assign i_rx.ready = !r_skid_valid;
    assign accept     = i_rx.valid && !r_skid_valid;

    always_comb begin
        case (r_pos)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase    = r_phase;
        n_fin      = r_fin;
        n_opcode   = r_opcode;
        n_mask     = r_mask;
        n_len_left = r_len_left;
        n_key_left = r_key_left;
        n_rem      = r_rem;
        n_flen     = r_flen;
        n_key      = r_key;
        n_pos      = r_pos;
        finish     = 1'b0;
        n_has_res  = 1'b0;
        n_res      = '0;
        case (r_phase)
            PH_SECOND: begin
                n_mask     = b[7];
                n_key      = '0;
                n_key_left = b[7] ? wsdf_pkg::KEY_BYTES : 3'd0;
                if (b[6:0] < wsdf_pkg::LEN_CODE_EXT16) begin
                    n_rem      = LENGTH_BITS'(b[6:0]);
                    n_len_left = 4'd0;
                end else begin
                    n_rem      = '0;
                    n_len_left = (b[6:0] == wsdf_pkg::LEN_CODE_EXT16) ?
                                 wsdf_pkg::EXT16_BYTES : wsdf_pkg::EXT64_BYTES;
                end
                if (n_len_left != 4'd0) begin
                    n_phase = PH_EXTLEN;
                end else if (n_key_left != 3'd0) begin
                    n_phase = PH_KEY;
                end else begin
                    finish = 1'b1;
                end
            end
            PH_EXTLEN: begin
                if (r_rem[LENGTH_BITS-1 -: 8] != 8'd0) begin
                    n_rem = '1;
                end else begin
                    n_rem = {r_rem[LENGTH_BITS-9:0], b};
                end
                n_len_left = r_len_left - 4'd1;
                if (n_len_left == 4'd0) begin
                    if (r_key_left != 3'd0) begin
                        n_phase = PH_KEY;
                    end else begin
                        finish = 1'b1;
                    end
                end
            end
            PH_KEY: begin
                n_key      = {r_key[23:0], b};
                n_key_left = r_key_left - 3'd1;
                if (n_key_left == 3'd0) begin
                    finish = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                n_pos     = r_pos + 2'd1;
                n_rem     = r_rem - LENGTH_BITS'(1);
                n_has_res = 1'b1;
                n_res.kind           = wsdf_pkg::KIND_PAYLOAD;
                n_res.payload_byte   = r_mask ? (b ^ key_byte) : b;
                n_res.frame_opcode   = r_opcode;
                n_res.final_fragment = r_fin;
                n_res.was_masked     = r_mask;
                n_res.payload_length = 64'(r_flen);
                n_res.end_of_frame   = (n_rem == '0);
                if (n_rem == '0) begin
                    n_phase = PH_FIRST;
                end
            end
            default: begin
                n_fin    = b[7];
                n_opcode = b[3:0];
                n_phase  = PH_SECOND;
            end
        endcase
        if (finish) begin
            n_flen    = n_rem;
            n_pos     = 2'd0;
            n_phase   = (n_rem == '0) ? PH_FIRST : PH_PAYLOAD;
            n_has_res = 1'b1;
            n_res.kind           = wsdf_pkg::KIND_HEADER;
            n_res.payload_byte   = 8'd0;
            n_res.frame_opcode   = r_opcode;
            n_res.final_fragment = r_fin;
            n_res.was_masked     = n_mask;
            n_res.payload_length = 64'(n_rem);
            n_res.end_of_frame   = (n_rem == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_FIRST;
            r_fin        <= 1'b0;
            r_opcode     <= 4'd0;
            r_mask       <= 1'b0;
            r_len_left   <= 4'd0;
            r_key_left   <= 3'd0;
            r_rem        <= '0;
            r_flen       <= '0;
            r_key        <= '0;
            r_pos        <= 2'd0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase    <= n_phase;
                r_fin      <= n_fin;
                r_opcode   <= n_opcode;
                r_mask     <= n_mask;
                r_len_left <= n_len_left;
                r_key_left <= n_key_left;
                r_rem      <= n_rem;
                r_flen     <= n_flen;
                r_key      <= n_key;
                r_pos      <= n_pos;
            end
            if (r_skid_valid) begin
                if (o_res.ready) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end
            end else if (accept && n_has_res) begin
                if (!r_out_valid || o_res.ready) begin
                    r_out       <= n_res;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid       <= n_res;
                    r_skid_valid <= 1'b1;
                end
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.kind           = r_out.kind;
    assign o_res.payload_byte   = r_out.payload_byte;
    assign o_res.frame_opcode   = r_out.frame_opcode;
    assign o_res.final_fragment = r_out.final_fragment;
    assign o_res.was_masked     = r_out.was_masked;
    assign o_res.payload_length = r_out.payload_length;
    assign o_res.end_of_frame   = r_out.end_of_frame;

endmodule

// ===== src/wsdf_checker.sv =====
// Port-level checker for the frame deframer, bound to the top level.
// Depends on websocket_frame_deframer_assert.svh and wsdf_pkg.
`include "websocket_frame_deframer_assert.svh"

module wsdf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_kind,
    input logic [7:0]  i_payload_byte,
    input logic [63:0] i_payload_length,
    input logic        i_end_of_frame
);

    // A stalled result holds its value until the transaction completes.
    `WSDF_ASSERT_RST(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_payload_byte) && $stable(i_payload_length) && $stable(i_kind), "stalled result changed")

    // A header result ends the frame exactly when the frame is empty.
    `WSDF_ASSERT_RST(a_hdr_eof, i_clk, i_rst_n, i_out_valid && i_kind == wsdf_pkg::KIND_HEADER |-> i_end_of_frame == (i_payload_length == 64'd0), "header end flag wrong")

    // A payload byte only belongs to a frame with a nonzero length.
    `WSDF_ASSERT_RST(a_pay_len, i_clk, i_rst_n, i_out_valid && i_kind == wsdf_pkg::KIND_PAYLOAD |-> i_payload_length != 64'd0, "payload in empty frame")

    // Header results carry a zero data byte.
    `WSDF_ASSERT_RST(a_hdr_byte, i_clk, i_rst_n, i_out_valid && i_kind == wsdf_pkg::KIND_HEADER |-> i_payload_byte == 8'd0, "header data byte not zero")

    // The output is empty on the cycle after reset.
    `WSDF_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

endmodule

bind websocket_frame_deframer wsdf_checker u_wsdf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_kind           (o_res.kind),
    .i_payload_byte   (o_res.payload_byte),
    .i_payload_length (o_res.payload_length),
    .i_end_of_frame   (o_res.end_of_frame)
);
